### hw/rtl/mf2c_pkg.sv
package mf2c_pkg;

  typedef struct packed {
    logic              op;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } mf2c_in_t;

  typedef struct packed {
    logic signed [15:0] left_median;
    logic signed [15:0] right_median;
    logic              frame_last;
  } mf2c_out_t;

  localparam logic       OP_SAMPLE = 1'b0;
  localparam logic       OP_DRAIN  = 1'b1;

  localparam logic [1:0] REG_NUM_ROWS    = 2'd0;
  localparam logic [1:0] REG_NUM_COLS    = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd2;

  localparam int MIN_WINDOW = 3;
  localparam int SAMPLE_W   = 16;

endpackage

### hw/rtl/median_filter_2d_clamped_unit.sv
// Two-channel 2D median filter with a square window and clamp-to-edge borders.
// Cells arrive in raster order; each result is the median of the window around
// the next pending output cell, released as soon as its window has arrived.
// Drain beats release the outputs still pending once the grid is complete.
// One beat is handled at a time. An item that releases an output first steps the
// line store base back to the window's top row, then the single line store read
// port fetches one window word per cycle, followed by a 16-step bit-serial rank
// select done for both channels at once. An item that releases nothing goes back
// to idle after its check. The line store needs no clearing pass.
module median_filter_2d_clamped_unit #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mf2c_pkg::mf2c_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mf2c_pkg::mf2c_out_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import mf2c_pkg::*;

  localparam int DEPTH   = MAX_WINDOW * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(MAX_COLS + 1);
  localparam int RW      = $clog2(MAX_ROWS + 1);
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int WIN_CAP = MAX_WINDOW * MAX_WINDOW;
  localparam int NW      = $clog2(WIN_CAP + 1);
  localparam int TOP_W   = (MAX_WINDOW - 1) | 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_BACK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_SEL   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [10:0] num_rows_r, num_cols_r;
  logic [2:0]  window_size_r;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [AW-1:0] in_addr_r, in_addr_nxt, out_base_r, out_base_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [WW-1:0] back_r, back_nxt, dr_r, dr_nxt, dc_r, dc_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [NW-1:0] kl_r, kl_nxt, kr_r, kr_nxt;
  logic [15:0]   pl_r, pl_nxt, pr_r, pr_nxt;
  logic [WIN_CAP-1:0] ml_r, ml_nxt, mr_r, mr_nxt;
  logic [15:0]   lane_l_r [WIN_CAP];
  logic [15:0]   lane_r_r [WIN_CAP];
  logic          cap_r;
  logic          out_valid_r, out_valid_nxt;
  mf2c_out_t     out_data_r, out_data_nxt;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en, wr_en;

  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [WW-1:0] w, h;
  logic [NW-1:0] n, k;
  logic [RW:0]   need_r;
  logic [CW:0]   need_c;
  logic          ready, last;
  logic [CW:0]   ctmp;
  logic [CW-1:0] sc;
  logic [AW:0]   asum, bsum;
  logic [RW:0]   tnext;
  logic [WIN_CAP-1:0] zl, zr;
  logic [NW-1:0] cnt_l, cnt_r;
  logic          accept;

  always_comb begin
    logic [2:0] wt;
    if (num_rows_r == 11'd0) rows = RW'(1);
    else if (32'(num_rows_r) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(num_rows_r);
    if (num_cols_r == 11'd0) cols = CW'(1);
    else if (32'(num_cols_r) > MAX_COLS) cols = CW'(MAX_COLS);
    else cols = CW'(num_cols_r);
    wt = window_size_r | 3'd1;
    if (32'(wt) < MIN_WINDOW) w = WW'(MIN_WINDOW);
    else if (32'(wt) > TOP_W) w = WW'(TOP_W);
    else w = WW'(wt);
    h = w >> 1;
    n = NW'(w) * NW'(w);
    k = n >> 1;
  end

  always_comb begin
    need_r = (RW + 1)'(out_row_r) + (RW + 1)'(h);
    if (need_r > (RW + 1)'(rows - RW'(1))) need_r = (RW + 1)'(rows - RW'(1));
    need_c = (CW + 1)'(out_col_r) + (CW + 1)'(h);
    if (need_c > (CW + 1)'(cols - CW'(1))) need_c = (CW + 1)'(cols - CW'(1));
    ready = ((RW + 1)'(in_row_r) > need_r) ||
            (((RW + 1)'(in_row_r) == need_r) && ((CW + 1)'(in_col_r) > need_c));
    last  = (out_row_r == rows - RW'(1)) && (out_col_r == cols - CW'(1));
  end

  always_comb begin
    ctmp = (CW + 1)'(out_col_r) + (CW + 1)'(dc_r);
    if (ctmp < (CW + 1)'(h)) sc = '0;
    else if (ctmp - (CW + 1)'(h) >= (CW + 1)'(cols)) sc = cols - CW'(1);
    else sc = CW'(ctmp - (CW + 1)'(h));
    asum = (AW + 1)'(base_r) + (AW + 1)'(sc);
    if (asum >= (AW + 1)'(DEPTH)) asum = asum - (AW + 1)'(DEPTH);
    rd_addr = AW'(asum);
    bsum = (AW + 1)'(base_r) + (AW + 1)'(cols);
    if (bsum >= (AW + 1)'(DEPTH)) bsum = bsum - (AW + 1)'(DEPTH);
    tnext = (RW + 1)'(out_row_r) + (RW + 1)'(dr_r) + (RW + 1)'(1);
  end

  always_comb begin
    for (int i = 0; i < WIN_CAP; i++) begin
      zl[i] = !(lane_l_r[i][bit_r] ^ (bit_r == 4'd15));
      zr[i] = !(lane_r_r[i][bit_r] ^ (bit_r == 4'd15));
    end
    cnt_l = NW'($countones(ml_r & zl));
    cnt_r = NW'($countones(mr_r & zr));
  end

  assign accept = in_valid && (state_r == S_IDLE);
  assign wr_en  = accept && (in_data.op == OP_SAMPLE) && (in_row_r < rows);
  assign rd_en  = (state_r == S_READ);

  always_comb begin
    logic [AW:0] sub;
    state_nxt     = state_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    in_addr_nxt   = in_addr_r;
    out_base_nxt  = out_base_r;
    base_nxt      = base_r;
    back_nxt      = back_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    bit_nxt       = bit_r;
    kl_nxt        = kl_r;
    kr_nxt        = kr_r;
    pl_nxt        = pl_r;
    pr_nxt        = pr_r;
    ml_nxt        = ml_r;
    mr_nxt        = mr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    sub           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (wr_en) begin
            in_addr_nxt = (32'(in_addr_r) == DEPTH - 1) ? '0 : in_addr_r + AW'(1);
            if (in_col_r + CW'(1) >= cols) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + RW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ready) begin
          base_nxt  = out_base_r;
          back_nxt  = ((RW + 1)'(out_row_r) < (RW + 1)'(h)) ? WW'(out_row_r) : h;
          dr_nxt    = '0;
          dc_nxt    = '0;
          state_nxt = S_BACK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BACK: begin
        if (back_r != '0) begin
          if ((AW + 1)'(base_r) >= (AW + 1)'(cols))
            sub = (AW + 1)'(base_r) - (AW + 1)'(cols);
          else
            sub = (AW + 1)'(base_r) + (AW + 1)'(DEPTH) - (AW + 1)'(cols);
          base_nxt = AW'(sub);
          back_nxt = back_r - WW'(1);
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (dc_r == w - WW'(1)) begin
          dc_nxt = '0;
          dr_nxt = dr_r + WW'(1);
          if (tnext > (RW + 1)'(h) && (tnext - (RW + 1)'(h)) <= (RW + 1)'(rows - RW'(1)))
            base_nxt = AW'(bsum);
          if (dr_r == w - WW'(1)) state_nxt = S_WAIT;
        end else begin
          dc_nxt = dc_r + WW'(1);
        end
      end
      S_WAIT: begin
        for (int i = 0; i < WIN_CAP; i++) begin
          ml_nxt[i] = (NW'(i) < n);
          mr_nxt[i] = (NW'(i) < n);
        end
        kl_nxt    = k;
        kr_nxt    = k;
        pl_nxt    = '0;
        pr_nxt    = '0;
        bit_nxt   = 4'd15;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (kl_r < cnt_l) begin
          ml_nxt = ml_r & zl;
        end else begin
          ml_nxt = ml_r & ~zl;
          kl_nxt = kl_r - cnt_l;
          pl_nxt[bit_r] = 1'b1;
        end
        if (kr_r < cnt_r) begin
          mr_nxt = mr_r & zr;
        end else begin
          mr_nxt = mr_r & ~zr;
          kr_nxt = kr_r - cnt_r;
          pr_nxt[bit_r] = 1'b1;
        end
        if (bit_r == 4'd0) state_nxt = S_EMIT;
        else bit_nxt = bit_r - 4'd1;
      end
      S_EMIT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.left_median  = pl_r ^ 16'h8000;
          out_data_nxt.right_median = pr_r ^ 16'h8000;
          out_data_nxt.frame_last   = last;
          if (last) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            in_addr_nxt  = '0;
            out_base_nxt = '0;
          end else if (out_col_r + CW'(1) >= cols) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + RW'(1);
            sub = (AW + 1)'(out_base_r) + (AW + 1)'(cols);
            if (sub >= (AW + 1)'(DEPTH)) sub = sub - (AW + 1)'(DEPTH);
            out_base_nxt = AW'(sub);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS ||
                   cfg_index == REG_WINDOW_SIZE)) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      in_addr_nxt  = '0;
      out_base_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[in_addr_r] <= {in_data.right_sample, in_data.left_sample};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cap_r) begin
      lane_l_r[0] <= rd_data_r[15:0];
      lane_r_r[0] <= rd_data_r[31:16];
      for (int i = 1; i < WIN_CAP; i++) begin
        lane_l_r[i] <= lane_l_r[i-1];
        lane_r_r[i] <= lane_r_r[i-1];
      end
    end
    base_r     <= base_nxt;
    back_r     <= back_nxt;
    dr_r       <= dr_nxt;
    dc_r       <= dc_nxt;
    bit_r      <= bit_nxt;
    kl_r       <= kl_nxt;
    kr_r       <= kr_nxt;
    pl_r       <= pl_nxt;
    pr_r       <= pr_nxt;
    ml_r       <= ml_nxt;
    mr_r       <= mr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cap_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      num_rows_r    <= 11'd1;
      num_cols_r    <= 11'd1;
      window_size_r <= 3'd3;
      in_row_r      <= '0;
      in_col_r      <= '0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      in_addr_r     <= '0;
      out_base_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= rd_en;
      out_valid_r <= out_valid_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      in_addr_r   <= in_addr_nxt;
      out_base_r  <= out_base_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS:    num_rows_r    <= cfg_data;
          REG_NUM_COLS:    num_cols_r    <= cfg_data;
          REG_WINDOW_SIZE: window_size_r <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
